// File: src/depthwise_conv3x3_u8_saturating_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depthwise 3x3 convolution block
// Shorthand for clocked implications under the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef DEPTHWISE_CONV3X3_U8_SATURATING_ASSERT_SVH
`define DEPTHWISE_CONV3X3_U8_SATURATING_ASSERT_SVH

// same-cycle implication
`define DWC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DWC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/dwc_pkg.sv
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared constants, types and helpers of the depthwise 3x3 convolution.
// ----------------------------------------------------------------------------
`default_nettype none

package dwc_pkg;

   localparam int DEF_MAX_HEIGHT   = 256;
   localparam int DEF_MAX_WIDTH    = 256;
   localparam int DEF_MAX_CHANNELS = 64;

   localparam int KERNEL_SIZE = 3;
   localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;

   // payload widths
   localparam int CMD_W    = 2;
   localparam int CHAN_W   = 6;
   localparam int TAP_W    = 4;
   localparam int PIX_W    = 8;
   localparam int BIAS_W   = 32;
   localparam int POS_W    = 8;
   localparam int HGT_W    = 9;
   localparam int WID_W    = 9;
   localparam int NCH_W    = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_BIAS   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PIXEL       = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_TAP,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // (s + k) mod 3 for s, k in 0..2
   function automatic logic [1:0] slot_add(input logic [1:0] s, input logic [1:0] k);
      logic [2:0] sum;
      sum = 3'(s) + 3'(k);
      return (sum >= 3'd3) ? 2'(sum - 3'd3) : 2'(sum);
   endfunction

   // (s - d) mod 3 for s, d in 0..2
   function automatic logic [1:0] slot_sub(input logic [1:0] s, input logic [1:0] d);
      return (s >= d) ? 2'(s - d) : 2'(3'(s) + 3'd3 - 3'(d));
   endfunction

endpackage

`default_nettype wire

// File: src/dwc_intf.sv
// ----------------------------------------------------------------------------
// dwc channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface dwc_req_if;
   logic                           valid;
   logic                           ready;
   logic [dwc_pkg::CMD_W-1:0]      cmd;
   logic [dwc_pkg::CHAN_W-1:0]     chan_index;
   logic [dwc_pkg::TAP_W-1:0]      tap_index;
   logic [dwc_pkg::PIX_W-1:0]      weight_value;
   logic signed [dwc_pkg::BIAS_W-1:0] bias_value;
   logic [dwc_pkg::PIX_W-1:0]      pixel_value;

   modport source (output valid, cmd, chan_index, tap_index, weight_value, bias_value,
                   pixel_value, input ready);
   modport sink   (input valid, cmd, chan_index, tap_index, weight_value, bias_value,
                   pixel_value, output ready);
endinterface

interface dwc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dwc_pkg::POS_W-1:0]   out_row;
   logic [dwc_pkg::POS_W-1:0]   out_col;
   logic [dwc_pkg::CHAN_W-1:0]  out_chan;
   logic [dwc_pkg::PIX_W-1:0]   out_value;
   logic                        run_last;

   modport source (output valid, out_row, out_col, out_chan, out_value, run_last,
                   input ready);
   modport sink   (input valid, out_row, out_col, out_chan, out_value, run_last,
                   output ready);
endinterface

interface dwc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [dwc_pkg::CSR_IDX_W-1:0]   index;
   logic [dwc_pkg::CSR_DAT_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/dwc_ram.sv
// ----------------------------------------------------------------------------
// dwc_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: src/depthwise_conv3x3_u8_saturating.sv
// ----------------------------------------------------------------------------
// depthwise_conv3x3_u8_saturating
// Per-channel 3x3 depthwise convolution over a streamed u8 image, with
// weight/bias tables and a three-row line store, results saturated to u8.
// ----------------------------------------------------------------------------
//   channel | dir | words carried
//   req_bus | in  | weight load, bias load or one pixel sample
//   rsp_bus | out | one convolution result (row, col, chan, value, run_last)
//   csr_bus | in  | geometry register write (height, width, channels)
//
// Loads and pixels that complete no output are taken in idle and start no walk.
// A pixel that completes N outputs (N up to 9) is accepted, then its bias is
// fetched; each output then walks nine taps through the line-store read port,
// one per cycle, drains the two-stage multiply pipe and is then emitted.
// After reset a clearing pass zeroes the weight and bias memories; no request
// is taken until it ends.
// A stalled result holds in the output register and stalls the tap walk.
// ----------------------------------------------------------------------------
`default_nettype none

module depthwise_conv3x3_u8_saturating #(
   parameter int MAX_HEIGHT   = dwc_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH    = dwc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = dwc_pkg::DEF_MAX_CHANNELS
) (
   input wire logic  clock,
   input wire logic  reset,
   dwc_req_if.sink   req_bus,
   dwc_rsp_if.source rsp_bus,
   dwc_csr_if.sink   csr_bus
);

   localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int NW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int HEW  = $clog2(MAX_HEIGHT + 1);
   localparam int WEW  = $clog2(MAX_WIDTH + 1);
   localparam int NEW  = $clog2(MAX_CHANNELS + 1);
   localparam int LS_DEPTH = dwc_pkg::KERNEL_SIZE * MAX_WIDTH * MAX_CHANNELS;
   localparam int LAW  = $clog2(LS_DEPTH);
   localparam int WT_DEPTH = MAX_CHANNELS * dwc_pkg::TAPS;
   localparam int WAW  = $clog2(WT_DEPTH);
   localparam int SLOT_SIZE = MAX_WIDTH * MAX_CHANNELS;

   dwc_pkg::state_type state_ff, state_in;

   // geometry registers
   logic [dwc_pkg::HGT_W-1:0] height_ff;
   logic [dwc_pkg::WID_W-1:0] width_ff;
   logic [dwc_pkg::NCH_W-1:0] nch_ff;
   logic [HEW-1:0] h_eff;
   logic [WEW-1:0] w_eff;
   logic [NEW-1:0] n_eff;

   // stream position
   logic [RW-1:0] row_ff;
   logic [CW-1:0] col_ff;
   logic [NW-1:0] chan_ff;
   logic [1:0]    slot_ff;

   // output walk
   logic [RW-1:0] r_ff, r_hi_ff;
   logic [CW-1:0] q_ff, q_lo_ff, q_hi_ff;
   logic [1:0]    r_slot_ff;
   logic [NW-1:0] pix_chan_ff;
   logic [WAW-1:0] w_base_ff;
   logic [dwc_pkg::TAP_W-1:0] tap_ff;
   logic [1:0]    kh_ff, kw_ff;
   logic          p1_ff, p2_ff;
   logic [15:0]   prod_ff;
   logic [31:0]   acc_ff, bias_ff;

   // clear pass
   logic [WAW-1:0] clr_ff;
   logic           clr_done;

   // result register
   logic                        rsp_valid_ff;
   logic [dwc_pkg::POS_W-1:0]   rsp_row_ff, rsp_col_ff;
   logic [dwc_pkg::CHAN_W-1:0]  rsp_chan_ff;
   logic [dwc_pkg::PIX_W-1:0]   rsp_value_ff;
   logic                        rsp_last_ff;
   logic                        rsp_free;

   // control
   logic req_acc, pix_acc, csr_acc;
   logic row_last, row_ge2, col_last, col_ge2, has_out;
   logic [RW-1:0] r_lo, r_hi;
   logic [CW-1:0] q_lo, q_hi;
   logic [1:0]    r_lo_slot;
   logic          tap_ok, out_last, chan_wrap, col_wrap, row_wrap;
   logic          tap_start, emit_go;

   // memory ports
   logic           ls_we;
   logic [LAW-1:0] ls_waddr, ls_raddr;
   logic [7:0]     ls_rdata;
   logic           wt_we;
   logic [WAW-1:0] wt_waddr, wt_raddr;
   logic [7:0]     wt_wdata, wt_rdata;
   logic           bs_we;
   logic [NW-1:0]  bs_waddr;
   logic [31:0]    bs_wdata, bs_rdata;

   logic [7:0]     sat_value;

   always_comb begin
      h_eff = (height_ff == '0) ? HEW'(1)
            : (32'(height_ff) > 32'(MAX_HEIGHT)) ? HEW'(MAX_HEIGHT) : HEW'(height_ff);
      w_eff = (width_ff == '0) ? WEW'(1)
            : (32'(width_ff) > 32'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : WEW'(width_ff);
      n_eff = (nch_ff == '0) ? NEW'(1)
            : (32'(nch_ff) > 32'(MAX_CHANNELS)) ? NEW'(MAX_CHANNELS) : NEW'(nch_ff);
   end

   assign req_acc = req_bus.valid && req_bus.ready;
   assign pix_acc = req_acc && (req_bus.cmd == dwc_pkg::CMD_PIXEL);
   assign csr_acc = csr_bus.valid && csr_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign clr_done = (32'(clr_ff) == 32'(WT_DEPTH - 1));

   // span of outputs completed by the current pixel
   always_comb begin
      row_last = (32'(row_ff) + 32'd1) == 32'(h_eff);
      row_ge2  = 32'(row_ff) >= 32'd2;
      col_last = (32'(col_ff) + 32'd1) == 32'(w_eff);
      col_ge2  = 32'(col_ff) >= 32'd2;
      has_out  = (row_last || row_ge2) && (col_last || col_ge2);
      r_lo     = row_ge2 ? RW'(32'(row_ff) - 32'd2) : '0;
      r_hi     = row_last ? row_ff : r_lo;
      q_lo     = col_ge2 ? CW'(32'(col_ff) - 32'd2) : '0;
      q_hi     = col_last ? col_ff : q_lo;
      r_lo_slot = dwc_pkg::slot_sub(slot_ff, row_ge2 ? 2'd2 : 2'(row_ff));
   end

   always_comb begin
      chan_wrap = (32'(chan_ff) + 32'd1) >= 32'(n_eff);
      col_wrap  = (32'(col_ff) + 32'd1) >= 32'(w_eff);
      row_wrap  = (32'(row_ff) + 32'd1) >= 32'(h_eff);
      tap_ok    = ((32'(r_ff) + 32'(kh_ff)) < 32'(h_eff))
               && ((32'(q_ff) + 32'(kw_ff)) < 32'(w_eff));
      out_last  = (r_ff == r_hi_ff) && (q_ff == q_hi_ff);
      sat_value = acc_ff[31] ? 8'd0 : ((acc_ff > 32'd255) ? 8'd255 : acc_ff[7:0]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dwc_pkg::ST_CLEAR: if (clr_done) state_in = dwc_pkg::ST_IDLE;
         dwc_pkg::ST_IDLE:  if (pix_acc && has_out) state_in = dwc_pkg::ST_LOAD;
         dwc_pkg::ST_LOAD:  state_in = dwc_pkg::ST_TAP;
         dwc_pkg::ST_TAP:   if (tap_ff == dwc_pkg::TAP_W'(dwc_pkg::TAPS - 1))
                               state_in = dwc_pkg::ST_DRAIN;
         dwc_pkg::ST_DRAIN: if (!p1_ff && !p2_ff) state_in = dwc_pkg::ST_EMIT;
         dwc_pkg::ST_EMIT: begin
            if (rsp_free) state_in = out_last ? dwc_pkg::ST_IDLE : dwc_pkg::ST_TAP;
         end
         default: state_in = dwc_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_bus.ready = (state_ff == dwc_pkg::ST_IDLE);
      tap_start     = (state_ff == dwc_pkg::ST_LOAD);
      emit_go       = (state_ff == dwc_pkg::ST_EMIT) && rsp_free;
   end

   assign csr_bus.ready = 1'b1;

   // memory port drive
   always_comb begin
      ls_we    = pix_acc;
      ls_waddr = LAW'(slot_ff) * LAW'(SLOT_SIZE) + LAW'(col_ff) * LAW'(MAX_CHANNELS)
               + LAW'(chan_ff);
      ls_raddr = LAW'(dwc_pkg::slot_add(r_slot_ff, kh_ff)) * LAW'(SLOT_SIZE)
               + LAW'(CW'(32'(q_ff) + 32'(kw_ff))) * LAW'(MAX_CHANNELS)
               + LAW'(pix_chan_ff);
      wt_raddr = w_base_ff + WAW'(tap_ff);

      if (state_ff == dwc_pkg::ST_CLEAR) begin
         wt_we    = 1'b1;
         wt_waddr = clr_ff;
         wt_wdata = '0;
         bs_we    = 32'(clr_ff) < 32'(MAX_CHANNELS);
         bs_waddr = NW'(clr_ff);
         bs_wdata = '0;
      end else begin
         wt_we    = req_acc && (req_bus.cmd == dwc_pkg::CMD_LOAD_WEIGHT)
                 && (32'(req_bus.chan_index) < 32'(MAX_CHANNELS))
                 && (32'(req_bus.tap_index) < 32'(dwc_pkg::TAPS));
         wt_waddr = WAW'(req_bus.chan_index) * WAW'(dwc_pkg::TAPS) + WAW'(req_bus.tap_index);
         wt_wdata = req_bus.weight_value;
         bs_we    = req_acc && (req_bus.cmd == dwc_pkg::CMD_LOAD_BIAS)
                 && (32'(req_bus.chan_index) < 32'(MAX_CHANNELS));
         bs_waddr = NW'(req_bus.chan_index);
         bs_wdata = req_bus.bias_value;
      end
   end

   dwc_ram #(.WIDTH(8), .DEPTH(LS_DEPTH)) u_line_store (
      .clock(clock), .wr_en(ls_we), .wr_addr(ls_waddr), .wr_data(req_bus.pixel_value),
      .rd_addr(ls_raddr), .rd_data(ls_rdata)
   );

   dwc_ram #(.WIDTH(8), .DEPTH(WT_DEPTH)) u_weight_table (
      .clock(clock), .wr_en(wt_we), .wr_addr(wt_waddr), .wr_data(wt_wdata),
      .rd_addr(wt_raddr), .rd_data(wt_rdata)
   );

   dwc_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_bias_table (
      .clock(clock), .wr_en(bs_we), .wr_addr(bs_waddr), .wr_data(bs_wdata),
      .rd_addr(chan_ff), .rd_data(bs_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dwc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         height_ff    <= dwc_pkg::HGT_W'(1);
         width_ff     <= dwc_pkg::WID_W'(1);
         nch_ff       <= dwc_pkg::NCH_W'(1);
         row_ff       <= '0;
         col_ff       <= '0;
         chan_ff      <= '0;
         slot_ff      <= '0;
         tap_ff       <= '0;
         kh_ff        <= '0;
         kw_ff        <= '0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == dwc_pkg::ST_CLEAR) clr_ff <= clr_ff + WAW'(1);

         if (csr_acc) begin
            case (csr_bus.index)
               dwc_pkg::REG_HEIGHT:   height_ff <= csr_bus.data;
               dwc_pkg::REG_WIDTH:    width_ff  <= csr_bus.data;
               dwc_pkg::REG_CHANNELS: nch_ff    <= csr_bus.data[dwc_pkg::NCH_W-1:0];
               default: ;
            endcase
            // any known register restarts the frame
            if (csr_bus.index == dwc_pkg::REG_HEIGHT || csr_bus.index == dwc_pkg::REG_WIDTH
                || csr_bus.index == dwc_pkg::REG_CHANNELS) begin
               row_ff  <= '0;
               col_ff  <= '0;
               chan_ff <= '0;
               slot_ff <= '0;
            end
         end else if (pix_acc) begin
            if (chan_wrap) begin
               chan_ff <= '0;
               if (col_wrap) begin
                  col_ff <= '0;
                  if (row_wrap) begin
                     row_ff  <= '0;
                     slot_ff <= '0;
                  end else begin
                     row_ff  <= row_ff + RW'(1);
                     slot_ff <= dwc_pkg::slot_add(slot_ff, 2'd1);
                  end
               end else begin
                  col_ff <= col_ff + CW'(1);
               end
            end else begin
               chan_ff <= chan_ff + NW'(1);
            end
         end

         // tap walk
         if (tap_start || (emit_go && !out_last)) begin
            tap_ff <= '0;
            kh_ff  <= '0;
            kw_ff  <= '0;
         end else if (state_ff == dwc_pkg::ST_TAP) begin
            tap_ff <= tap_ff + dwc_pkg::TAP_W'(1);
            if (kw_ff == 2'd2) begin
               kw_ff <= '0;
               kh_ff <= kh_ff + 2'd1;
            end else begin
               kw_ff <= kw_ff + 2'd1;
            end
         end

         p1_ff <= (state_ff == dwc_pkg::ST_TAP) && tap_ok;
         p2_ff <= p1_ff;

         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pix_acc) begin
         r_ff        <= r_lo;
         r_hi_ff     <= r_hi;
         q_ff        <= q_lo;
         q_lo_ff     <= q_lo;
         q_hi_ff     <= q_hi;
         r_slot_ff   <= r_lo_slot;
         pix_chan_ff <= chan_ff;
         w_base_ff   <= WAW'(chan_ff) * WAW'(dwc_pkg::TAPS);
      end else if (emit_go && !out_last) begin
         // advance column, then row
         if (q_ff == q_hi_ff) begin
            q_ff      <= q_lo_ff;
            r_ff      <= r_ff + RW'(1);
            r_slot_ff <= dwc_pkg::slot_add(r_slot_ff, 2'd1);
         end else begin
            q_ff <= q_ff + CW'(1);
         end
      end

      prod_ff <= ls_rdata * wt_rdata;

      if (tap_start) begin
         bias_ff <= bs_rdata;
         acc_ff  <= bs_rdata;
      end else if (emit_go) begin
         acc_ff <= bias_ff;
      end else if (p2_ff) begin
         acc_ff <= acc_ff + 32'(prod_ff);
      end

      if (emit_go) begin
         rsp_row_ff   <= dwc_pkg::POS_W'(r_ff);
         rsp_col_ff   <= dwc_pkg::POS_W'(q_ff);
         rsp_chan_ff  <= dwc_pkg::CHAN_W'(pix_chan_ff);
         rsp_value_ff <= sat_value;
         rsp_last_ff  <= out_last;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_row   = rsp_row_ff;
   assign rsp_bus.out_col   = rsp_col_ff;
   assign rsp_bus.out_chan  = rsp_chan_ff;
   assign rsp_bus.out_value = rsp_value_ff;
   assign rsp_bus.run_last  = rsp_last_ff;

`include "depthwise_conv3x3_u8_saturating_assert.svh"

   `DWC_ASSERT_NEXT(a_emit_loads_rsp, emit_go, rsp_valid_ff, "emit did not load result")
   `DWC_ASSERT_NOW(a_idle_pipe_empty, state_ff == dwc_pkg::ST_IDLE, !p1_ff && !p2_ff,
   "multiply pipe busy while idle")
   `DWC_ASSERT_NOW(a_tap_range, state_ff == dwc_pkg::ST_TAP,
   tap_ff < dwc_pkg::TAP_W'(dwc_pkg::TAPS), "tap index out of kernel")
   `DWC_ASSERT_NEXT(a_pixel_starts_walk, pix_acc && has_out, state_ff == dwc_pkg::ST_LOAD,
   "pixel with outputs did not start walk")

endmodule

`default_nettype wire
